// ===== rtl/sts_pkg.sv =====
// Shared constants, payload types and state encodings for the stereo transient shaper.
package sts_pkg;

  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned ENV_BITS       = SAMPLE_BITS - 1;
  localparam int unsigned COEFF_BITS     = 24;
  localparam int unsigned SCALE_BITS     = 17;
  localparam int unsigned SCALE_FRAC     = 12;
  localparam int unsigned OUT_SHIFT      = 16;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 24;
  localparam int unsigned TR_BITS        = 18;
  localparam int unsigned SU_BITS        = 17;
  localparam int unsigned QUO_BITS       = 18;
  localparam int unsigned GAIN_BITS      = 24;

  localparam logic [ENV_BITS-1:0] SMAX      = {ENV_BITS{1'b1}};
  localparam logic [ENV_BITS-1:0] DIV_FLOOR = ENV_BITS'(8);
  localparam logic [QUO_BITS-1:0] ONE_Q16   = QUO_BITS'(65536);
  localparam logic [TR_BITS-1:0]  TR_MAX    = TR_BITS'(131072);

  localparam logic [COEFF_BITS-1:0] FAST_ATTACK_RST  = COEFF_BITS'(69760);
  localparam logic [COEFF_BITS-1:0] FAST_RELEASE_RST = COEFF_BITS'(2330);
  localparam logic [COEFF_BITS-1:0] SLOW_ATTACK_RST  = COEFF_BITS'(5825);
  localparam logic [COEFF_BITS-1:0] SLOW_RELEASE_RST = COEFF_BITS'(699);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FAST_ATTACK   = 3'd0,
    REG_FAST_RELEASE  = 3'd1,
    REG_SLOW_ATTACK   = 3'd2,
    REG_SLOW_RELEASE  = 3'd3,
    REG_ATTACK_SCALE  = 3'd4,
    REG_SUSTAIN_SCALE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_pair_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_FAST_MUL,
    ST_FAST_UPD,
    ST_SLOW_UPD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ATK_MUL,
    ST_SUS_MUL,
    ST_GAIN,
    ST_LEFT_MUL,
    ST_LEFT_OUT,
    ST_RIGHT_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SETUP,
    DIV_ITER,
    DIV_DONE
  } div_state_e;

endpackage

// ===== rtl/sts_div.sv =====
// Iterative restoring divider that turns the two envelopes into the clamped transient value.
module sts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sts_pkg::ENV_BITS-1:0] fast_i,
  input  logic [sts_pkg::ENV_BITS-1:0] slow_i,
  output logic                         done_o,
  output logic [sts_pkg::TR_BITS-1:0]  tr_o
);
  import sts_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(QUO_BITS);

  div_state_e state_q, state_d;

  logic [ENV_BITS-1:0] fast_q;
  logic [ENV_BITS-1:0] den_q;
  logic [ENV_BITS-1:0] rem_q;
  logic [QUO_BITS-1:0] quo_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                sat_q;

  logic [ENV_BITS+1:0] den_x3;
  logic                next_bit;
  logic [ENV_BITS:0]   rem_shift;
  logic [ENV_BITS:0]   rem_sub;
  logic                rem_ge;

  // The dividend is the fast envelope shifted up by 16; only its two low bits reach the
  // quotient window, the rest enters through the initial remainder.
  assign den_x3    = {2'b00, den_q} + {1'b0, den_q, 1'b0};
  assign next_bit  = (cnt_q >= CNT_BITS'(OUT_SHIFT)) ? fast_q[cnt_q[0]] : 1'b0;
  assign rem_shift = {rem_q, next_bit};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = DIV_SETUP;
        end
      end
      DIV_SETUP: state_d = DIV_ITER;
      DIV_ITER: begin
        if (cnt_q == '0) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == DIV_DONE);
    if (sat_q) begin
      tr_o = TR_MAX;
    end else if (quo_q < ONE_Q16) begin
      tr_o = '0;
    end else begin
      tr_o = TR_BITS'(quo_q - ONE_Q16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          fast_q <= fast_i;
          den_q  <= (slow_i > DIV_FLOOR) ? slow_i : DIV_FLOOR;
        end
      end
      DIV_SETUP: begin
        sat_q <= ({2'b00, fast_q} >= den_x3);
        rem_q <= fast_q >> 2;
        quo_q <= '0;
        cnt_q <= CNT_BITS'(QUO_BITS - 1);
      end
      DIV_ITER: begin
        rem_q <= rem_ge ? rem_sub[ENV_BITS-1:0] : rem_shift[ENV_BITS-1:0];
        quo_q <= {quo_q[QUO_BITS-2:0], rem_ge};
        cnt_q <= cnt_q - CNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/stereo_transient_shaper.sv =====
// Top level of the stereo transient shaper: registers, sequencer and shared multiplier.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_ready_o | in_data_i (left_in, right_in)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (left_out, right_out)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A new pair is accepted only while idle, once the last result is in the output register;
// each pair uses the 18-step restoring divider and six passes through the shared multiplier.
// Reset clears the configuration to its defaults and both envelopes to zero.
// A finished result sits in the output register while the next pair is accepted;
// the sequencer stalls only if a second result is ready before the first is taken.
// The configuration port is always ready.
module stereo_transient_shaper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sts_pkg::in_pair_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sts_pkg::out_pair_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import sts_pkg::*;

  localparam int unsigned AW     = (SAMPLE_BITS > TR_BITS + 1) ? SAMPLE_BITS : TR_BITS + 1;
  localparam int unsigned BW     = COEFF_BITS + 1;
  localparam int unsigned PW     = AW + BW;
  localparam int unsigned STEP_W = PW - COEFF_BITS;
  localparam int unsigned SUM_W  = STEP_W + 1;
  localparam int unsigned Q_W    = PW - OUT_SHIFT;
  localparam int unsigned ACC_W  = 37;
  localparam int unsigned GSH_W  = ACC_W - SCALE_FRAC;

  localparam logic signed [PW-1:0]    ENV_HALF  = PW'(1) << (COEFF_BITS - 1);
  localparam logic signed [PW-1:0]    OUT_HALF  = PW'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(1) << (SCALE_FRAC - 1);
  localparam logic signed [ACC_W-1:0] GAIN_BASE = ACC_W'(1) << (SCALE_FRAC + OUT_SHIFT);

  function automatic logic [ENV_BITS-1:0] mag_sat(logic signed [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] m;
    m = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
    return m[SAMPLE_BITS-1] ? SMAX : m[ENV_BITS-1:0];
  endfunction

  function automatic logic [ENV_BITS-1:0] env_next(logic [ENV_BITS-1:0] env,
                                                   logic signed [PW-1:0] p);
    logic signed [PW-1:0]     rnd;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;
    rnd  = p + ENV_HALF;
    step = rnd[PW-1:COEFF_BITS];
    sum  = $signed({{(SUM_W-ENV_BITS){1'b0}}, env}) + SUM_W'(step);
    if (sum[SUM_W-1]) begin
      return '0;
    end else if (|sum[SUM_W-2:ENV_BITS]) begin
      return SMAX;
    end
    return sum[ENV_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] out_sat(logic signed [PW-1:0] p);
    logic signed [PW-1:0]  rnd;
    logic signed [Q_W-1:0] q;
    logic [Q_W-SAMPLE_BITS:0] top;
    rnd = p + OUT_HALF;
    q   = rnd[PW-1:OUT_SHIFT];
    top = q[Q_W-1:SAMPLE_BITS-1];
    if ((&top) || (~|top)) begin
      return q[SAMPLE_BITS-1:0];
    end
    return q[Q_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  state_e state_q, state_d;

  logic [COEFF_BITS-1:0]        fast_atk_q, fast_rel_q, slow_atk_q, slow_rel_q;
  logic signed [SCALE_BITS-1:0] atk_scale_q, sus_scale_q;
  logic [ENV_BITS-1:0]          fast_env_q, slow_env_q;

  logic signed [SAMPLE_BITS-1:0] left_in_q, right_in_q, left_res_q;
  logic [ENV_BITS-1:0]           peak_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic [TR_BITS-1:0]            tr_q;
  logic [GAIN_BITS-1:0]          gain_q;
  out_pair_t                     out_q;
  logic                          out_valid_q;

  logic                          out_free;
  logic                          div_start;
  logic                          div_done;
  logic [TR_BITS-1:0]            div_tr;
  logic                          mul_en;
  logic signed [AW-1:0]          mul_a;
  logic signed [BW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic [ENV_BITS-1:0]           env_sel;
  logic signed [SAMPLE_BITS-1:0] diff;
  logic [SU_BITS-1:0]            sustain;
  logic signed [ACC_W-1:0]       gsum;
  logic signed [GSH_W-1:0]       gsh;
  logic signed [SAMPLE_BITS-1:0] right_res;

  sts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .fast_i (fast_env_q),
    .slow_i (slow_env_q),
    .done_o (div_done),
    .tr_o   (div_tr)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign env_sel   = (state_q == ST_FAST_MUL) ? fast_env_q : slow_env_q;
  assign diff      = $signed({1'b0, peak_q}) - $signed({1'b0, env_sel});
  assign sustain   = SU_BITS'(ONE_Q16) - SU_BITS'(tr_q >> 1);
  assign prod      = mul_a * mul_b;
  assign gsum      = acc_q + $signed(prod_q[ACC_W-1:0]) + GAIN_HALF;
  assign gsh       = gsum[ACC_W-1:SCALE_FRAC];
  assign right_res = out_sat(prod_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PEAK;
        end
      end
      ST_PEAK:      state_d = ST_FAST_MUL;
      ST_FAST_MUL:  state_d = ST_FAST_UPD;
      ST_FAST_UPD:  state_d = ST_SLOW_UPD;
      ST_SLOW_UPD:  state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_ATK_MUL;
        end
      end
      ST_ATK_MUL:  state_d = ST_SUS_MUL;
      ST_SUS_MUL:  state_d = ST_GAIN;
      ST_GAIN:     state_d = ST_LEFT_MUL;
      ST_LEFT_MUL: state_d = ST_LEFT_OUT;
      ST_LEFT_OUT: state_d = ST_RIGHT_OUT;
      ST_RIGHT_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mul_en     = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mul_en     = 1'b0;
      end
      ST_FAST_MUL: begin
        mul_a = AW'(diff);
        mul_b = {1'b0, (peak_q > env_sel) ? fast_atk_q : fast_rel_q};
      end
      ST_FAST_UPD: begin
        mul_a = AW'(diff);
        mul_b = {1'b0, (peak_q > env_sel) ? slow_atk_q : slow_rel_q};
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        mul_en    = 1'b0;
      end
      ST_ATK_MUL: begin
        mul_a = AW'(tr_q);
        mul_b = BW'(atk_scale_q);
      end
      ST_SUS_MUL: begin
        mul_a = AW'(sustain);
        mul_b = BW'(sus_scale_q);
      end
      ST_LEFT_MUL: begin
        mul_a = AW'(left_in_q);
        mul_b = {1'b0, gain_q};
      end
      ST_LEFT_OUT: begin
        mul_a = AW'(right_in_q);
        mul_b = {1'b0, gain_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      fast_env_q  <= '0;
      slow_env_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FAST_UPD) begin
        fast_env_q <= env_next(fast_env_q, prod_q);
      end
      if (state_q == ST_SLOW_UPD) begin
        slow_env_q <= env_next(slow_env_q, prod_q);
      end
      if ((state_q == ST_RIGHT_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_atk_q  <= FAST_ATTACK_RST;
      fast_rel_q  <= FAST_RELEASE_RST;
      slow_atk_q  <= SLOW_ATTACK_RST;
      slow_rel_q  <= SLOW_RELEASE_RST;
      atk_scale_q <= '0;
      sus_scale_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FAST_ATTACK:   fast_atk_q  <= cfg_data_i[COEFF_BITS-1:0];
        REG_FAST_RELEASE:  fast_rel_q  <= cfg_data_i[COEFF_BITS-1:0];
        REG_SLOW_ATTACK:   slow_atk_q  <= cfg_data_i[COEFF_BITS-1:0];
        REG_SLOW_RELEASE:  slow_rel_q  <= cfg_data_i[COEFF_BITS-1:0];
        REG_ATTACK_SCALE:  atk_scale_q <= cfg_data_i[SCALE_BITS-1:0];
        REG_SUSTAIN_SCALE: sus_scale_q <= cfg_data_i[SCALE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          left_in_q  <= in_data_i.left_in;
          right_in_q <= in_data_i.right_in;
        end
      end
      ST_PEAK: begin
        peak_q <= (mag_sat(left_in_q) > mag_sat(right_in_q)) ? mag_sat(left_in_q)
                                                             : mag_sat(right_in_q);
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          tr_q <= div_tr;
        end
      end
      ST_SUS_MUL: begin
        acc_q <= GAIN_BASE + $signed(prod_q[ACC_W-1:0]);
      end
      ST_GAIN: begin
        gain_q <= gsh[GSH_W-1] ? '0 : gsh[GAIN_BITS-1:0];
      end
      ST_LEFT_OUT: begin
        left_res_q <= out_sat(prod_q);
      end
      ST_RIGHT_OUT: begin
        if (out_free) begin
          out_q.left_out  <= left_res_q;
          out_q.right_out <= right_res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== verif/sts_gain_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stereo transient shaper: predicts every shaped sample pair and compares it with the output.
module sts_gain_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  sts_pkg::in_pair_t                  in_data_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  sts_pkg::out_pair_t                 out_data_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               run_done_i,
  output int                                 pairs_out_o,
  output int                                 failures_o
);
  import sts_pkg::*;

  localparam longint ENV_TOP    = (longint'(1) << ENV_BITS) - 1;
  localparam longint SAMPLE_TOP = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  longint fast_attack;
  longint fast_release;
  longint slow_attack;
  longint slow_release;
  longint attack_scale;
  longint sustain_scale;
  longint fast_env;
  longint slow_env;

  out_pair_t shaped_q[$];
  int        failures  = 0;
  int        pairs_out = 0;
  bit        done_seen = 1'b0;

  assign failures_o  = failures;
  assign pairs_out_o = pairs_out;

  task automatic report_mismatch(input string what);
    failures++;
    $display("[%0t] sts_gain_checker: %s", $time, what);
  endtask

  function automatic longint follow_env(input longint env, input longint peak,
                                        input longint atk, input longint rel);
    longint coeff;
    longint next;
    coeff = (peak > env) ? atk : rel;
    next  = env + ((coeff * (peak - env) + (longint'(1) << 23)) >>> 24);
    if (next < 0) next = 0;
    if (next > ENV_TOP) next = ENV_TOP;
    return next;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(input longint sample,
                                                                input longint gain);
    longint v;
    v = (sample * gain + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (v > SAMPLE_TOP) v = SAMPLE_TOP;
    if (v < -SAMPLE_TOP - 1) v = -SAMPLE_TOP - 1;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Advances both envelopes by one pair and returns the shaped pair.
  function automatic out_pair_t shape_pair(input in_pair_t pair);
    longint    left;
    longint    right;
    longint    peak;
    longint    den;
    longint    ratio;
    longint    trans;
    longint    sus;
    longint    gain;
    out_pair_t res;
    left  = pair.left_in;
    right = pair.right_in;
    peak  = (left < 0) ? -left : left;
    if (right < 0 && -right > peak) peak = -right;
    if (right >= 0 && right > peak) peak = right;
    if (peak > ENV_TOP) peak = ENV_TOP;
    fast_env = follow_env(fast_env, peak, fast_attack, fast_release);
    slow_env = follow_env(slow_env, peak, slow_attack, slow_release);
    den   = (slow_env > longint'(DIV_FLOOR)) ? slow_env : longint'(DIV_FLOOR);
    ratio = (fast_env << 16) / den;
    trans = ratio - longint'(ONE_Q16);
    if (trans < 0) trans = 0;
    if (trans > longint'(TR_MAX)) trans = longint'(TR_MAX);
    sus  = longint'(ONE_Q16) - (trans >>> 1);
    gain = (longint'(ONE_Q16) << SCALE_FRAC) + attack_scale * trans + sustain_scale * sus;
    gain = (gain + (longint'(1) << (SCALE_FRAC - 1))) >>> SCALE_FRAC;
    if (gain < 0) gain = 0;
    res.left_out  = apply_gain(left, gain);
    res.right_out = apply_gain(right, gain);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_pair_t want;
    if (!rst_ni) begin
      fast_attack   = FAST_ATTACK_RST;
      fast_release  = FAST_RELEASE_RST;
      slow_attack   = SLOW_ATTACK_RST;
      slow_release  = SLOW_RELEASE_RST;
      attack_scale  = 0;
      sustain_scale = 0;
      fast_env      = 0;
      slow_env      = 0;
      shaped_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FAST_ATTACK:   fast_attack   = cfg_data_i[COEFF_BITS-1:0];
          REG_FAST_RELEASE:  fast_release  = cfg_data_i[COEFF_BITS-1:0];
          REG_SLOW_ATTACK:   slow_attack   = cfg_data_i[COEFF_BITS-1:0];
          REG_SLOW_RELEASE:  slow_release  = cfg_data_i[COEFF_BITS-1:0];
          REG_ATTACK_SCALE:  attack_scale  = signed'(cfg_data_i[SCALE_BITS-1:0]);
          REG_SUSTAIN_SCALE: sustain_scale = signed'(cfg_data_i[SCALE_BITS-1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        pairs_out <= pairs_out + 1;
        if (shaped_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no pair waiting",
                                    out_data_i.left_out, out_data_i.right_out));
        end else begin
          want = shaped_q.pop_front();
          if (out_data_i.left_out !== want.left_out) begin
            report_mismatch($sformatf("left_out got %0d, expected %0d",
                                      out_data_i.left_out, want.left_out));
          end
          if (out_data_i.right_out !== want.right_out) begin
            report_mismatch($sformatf("right_out got %0d, expected %0d",
                                      out_data_i.right_out, want.right_out));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        shaped_q.push_back(shape_pair(in_data_i));
      end
      if (run_done_i && !done_seen) begin
        done_seen = 1'b1;
        if (shaped_q.size() != 0) begin
          report_mismatch($sformatf("%0d shaped pairs never came out", shaped_q.size()));
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the stereo transient shaper: clock, reset, stimulus, idling and verdict.
module testbench;
  import sts_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RUN_CYCLES    = 1_500_000;
  localparam int DRAIN_CYCLES  = 5000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 6;
  localparam int PHASE_PAIRS   = 300;
  localparam int STEADY_PHASE  = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [SCALE_BITS-1:0]     SCALE_LO     = SCALE_BITS'(-3686);
  localparam logic [SCALE_BITS-1:0]     SCALE_HI     = SCALE_BITS'(36864);
  localparam logic [SCALE_BITS-1:0]     SCALE_NEG    = SCALE_BITS'(-65536);
  localparam logic [SCALE_BITS-1:0]     SCALE_POS    = SCALE_BITS'(65535);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_pair_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_pair_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      run_done  = 1'b0;

  bit steady     = 1'b0;
  int stall_left = 0;
  int pairs_sent = 0;
  int settings   = 0;
  int pairs_out;
  int failures;

  stereo_transient_shaper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sts_gain_checker gain_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .run_done_i  (run_done),
    .pairs_out_o (pairs_out),
    .failures_o  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * RUN_CYCLES);
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 999) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(20, 80);
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] left,
                           input logic signed [SAMPLE_BITS-1:0] right);
    if (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_in: left, right_in: right};
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_CYCLES && pairs_out < pairs_sent; w++) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(input logic [CFG_DATA_BITS-1:0] fast_atk, fast_rel,
                              input logic [CFG_DATA_BITS-1:0] slow_atk, slow_rel,
                              input logic [CFG_DATA_BITS-1:0] atk_word, sus_word);
    write_reg(REG_FAST_ATTACK, fast_atk);
    write_reg(REG_FAST_RELEASE, fast_rel);
    write_reg(REG_SLOW_ATTACK, slow_atk);
    write_reg(REG_SLOW_RELEASE, slow_rel);
    write_reg(REG_ATTACK_SCALE, atk_word);
    write_reg(REG_SUSTAIN_SCALE, sus_word);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
              CFG_DATA_BITS'($urandom()));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Upper bits above the scale width are random and must be dropped by the block.
  function automatic logic [CFG_DATA_BITS-1:0] scale_word(input logic [SCALE_BITS-1:0] s);
    logic [CFG_DATA_BITS-1:0] d;
    d = CFG_DATA_BITS'($urandom());
    d[SCALE_BITS-1:0] = s;
    return d;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {COEFF_BITS{1'b1}};
      2:       return CFG_DATA_BITS'($urandom_range(1, 4095));
      3:       return CFG_DATA_BITS'($urandom_range(1, 131071));
      default: return CFG_DATA_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return scale_word(SCALE_LO);
      1:       return scale_word(SCALE_HI);
      2:       return scale_word(SCALE_BITS'($urandom()));
      3:       return scale_word('0);
      default: return scale_word(SCALE_BITS'($urandom_range(0, 40550) - 3686));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input int span);
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 24))
      0:       v = SAMPLE_MAX;
      1:       v = SAMPLE_MIN;
      2:       v = '0;
      default: begin
        v = SAMPLE_BITS'($urandom());
        v = v <<< (SAMPLE_BITS - span);
        v = v >>> (SAMPLE_BITS - span);
      end
    endcase
    return v;
  endfunction

  initial begin
    int seg_left;
    int span;
    seg_left = 0;
    span     = SAMPLE_BITS;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd1, -24'sd1);
    send_pair(-24'sd8, 24'sd7);
    send_pair(SAMPLE_MAX, 24'sd0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(24'sd0, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(-24'sd1, SAMPLE_MAX);
    drain();

    load_setting({COEFF_BITS{1'b1}}, {COEFF_BITS{1'b1}}, '0, '0,
                 scale_word(SCALE_HI), scale_word(SCALE_LO));
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, 24'sd0);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd1234, -24'sd5678);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(24'sd4, -24'sd3);
    drain();

    load_setting('0, {COEFF_BITS{1'b1}}, {COEFF_BITS{1'b1}}, 24'd1,
                 scale_word(SCALE_NEG), scale_word(SCALE_POS));
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(24'sd0, 24'sd0);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(24'sd100, -24'sd100);
    send_pair(SAMPLE_MAX, 24'sd1);
    send_pair(24'sd0, 24'sd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_setting({COEFF_BITS{1'b1}}, {COEFF_BITS{1'b1}}, SLOW_ATTACK_RST,
                        SLOW_RELEASE_RST, scale_word(SCALE_HI), scale_word(SCALE_HI));
        1: load_setting({COEFF_BITS{1'b1}}, '0, '0, '0,
                        scale_word(SCALE_LO), scale_word(SCALE_LO));
        default: load_setting(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                              pick_scale(), pick_scale());
      endcase
      steady = (p == STEADY_PHASE);
      for (int k = 0; k < PHASE_PAIRS; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(4, 60);
          case ($urandom_range(0, 6))
            0:       span = 2;
            1:       span = 6;
            2:       span = 12;
            3:       span = 18;
            4:       span = 22;
            default: span = SAMPLE_BITS;
          endcase
        end
        seg_left--;
        send_pair(draw_sample(span), draw_sample(span));
      end
      drain();
      steady = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("testbench: %0d sample pairs over reset defaults and %0d register settings",
             pairs_sent, settings);
    $display("testbench: %0d shaped pairs compared under random input gaps and output stalls",
             pairs_out);
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
